[rtl/aass_pkg.sv]
// Shared types and constants for the ADC averaging scan sequencer.
package aass_pkg;

  localparam int unsigned SAMPLE_W = 10;
  localparam int unsigned SUM_W    = SAMPLE_W + 4;
  localparam int unsigned CNT_W    = 4;
  localparam int unsigned DIVIN_W  = SUM_W + 1;
  localparam int unsigned NUM_CH   = 4;
  localparam int unsigned CH_W     = 2;

  typedef enum logic [2:0] {
    OP_OPEN   = 3'd0,
    OP_CLOSE  = 3'd1,
    OP_SCAN   = 3'd2,
    OP_CUR    = 3'd3,
    OP_SAMPLE = 3'd4
  } opcode_e;

  typedef enum logic [6:0] {
    MODE_IDLE  = 7'b000_0001,
    MODE_READY = 7'b000_0010,
    MODE_CH0   = 7'b000_0100,
    MODE_CH1   = 7'b000_1000,
    MODE_CH2   = 7'b001_0000,
    MODE_CH3   = 7'b010_0000,
    MODE_CUR   = 7'b100_0000
  } mode_e;

  localparam logic [CH_W-1:0] CH_CUR = 2'd3;

  typedef struct packed {
    logic [2:0]          opcode;
    logic [SAMPLE_W-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic                ok;
    logic                request_valid;
    logic [CH_W-1:0]     request_channel;
    logic                done_res;
    logic [SAMPLE_W-1:0] average_ch0;
    logic [SAMPLE_W-1:0] average_ch1;
    logic [SAMPLE_W-1:0] average_ch2;
    logic [SAMPLE_W-1:0] average_ch3;
    logic [SAMPLE_W-1:0] current_average;
  } out_item_t;

endpackage

[rtl/aass_div.sv]
// Rounded-mean divider: exact division by a constant via reciprocal multiply.
module aass_div
  import aass_pkg::*;
#(
  parameter int unsigned SAMPLES_PER_CHANNEL = 10
) (
  input  logic [DIVIN_W-1:0]  dividend_i,
  output logic [SAMPLE_W-1:0] quot_o
);

  // Shift = dividend width + 4 keeps floor(x*m >> Shift) exact for divisors up to 16.
  localparam int unsigned Shift  = DIVIN_W + 4;
  localparam int unsigned RecipW = Shift + 1;
  localparam int unsigned ProdW  = DIVIN_W + RecipW;
  localparam logic [RecipW-1:0] Recip =
    RecipW'(((64'd1 << Shift) + 64'(SAMPLES_PER_CHANNEL) - 64'd1) / 64'(SAMPLES_PER_CHANNEL));

  logic [ProdW-1:0] prod;

  assign prod   = ProdW'(dividend_i) * ProdW'(Recip);
  assign quot_o = prod[Shift +: SAMPLE_W];

endmodule

[rtl/aass_seq.sv]
// Sequencer state and per-request step logic.
module aass_seq
  import aass_pkg::*;
#(
  parameter int unsigned SAMPLES_PER_CHANNEL = 10
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  in_item_t  item_i,
  output out_item_t res_o
);

  localparam logic [CNT_W-1:0]   NCnt = CNT_W'(SAMPLES_PER_CHANNEL);
  localparam logic [DIVIN_W-1:0] Half = DIVIN_W'(SAMPLES_PER_CHANNEL / 2);

  mode_e               mode_q, mode_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic [SAMPLE_W-1:0] avg_q [NUM_CH];
  logic [SAMPLE_W-1:0] avg_d [NUM_CH];
  logic [SAMPLE_W-1:0] cur_q, cur_d;

  logic [CNT_W-1:0]    cnt_inc;
  logic [SUM_W-1:0]    sum_inc;
  logic [SAMPLE_W-1:0] mean;
  logic [CH_W-1:0]     scan_ch;
  logic                ok, req, done;
  logic [CH_W-1:0]     chan;

  assign cnt_inc = cnt_q + CNT_W'(1);
  assign sum_inc = sum_q + SUM_W'(item_i.sample);

  aass_div #(
    .SAMPLES_PER_CHANNEL(SAMPLES_PER_CHANNEL)
  ) u_div (
    .dividend_i(DIVIN_W'(sum_inc) + Half),
    .quot_o    (mean)
  );

  always_comb begin
    case (mode_q)
      MODE_CH1: scan_ch = 2'd1;
      MODE_CH2: scan_ch = 2'd2;
      MODE_CH3: scan_ch = 2'd3;
      default:  scan_ch = 2'd0;
    endcase
  end

  always_comb begin
    mode_d = mode_q;
    cnt_d  = cnt_q;
    sum_d  = sum_q;
    avg_d  = avg_q;
    cur_d  = cur_q;
    ok     = 1'b0;
    req    = 1'b0;
    chan   = '0;
    done   = 1'b0;
    case (item_i.opcode)
      OP_OPEN: begin
        if (mode_q == MODE_IDLE) begin
          mode_d = MODE_READY;
          ok     = 1'b1;
        end
      end
      OP_CLOSE: begin
        // sum and count stay; the next start clears them
        if (mode_q != MODE_IDLE) begin
          mode_d = MODE_IDLE;
          ok     = 1'b1;
        end
      end
      OP_SCAN, OP_CUR: begin
        if (mode_q == MODE_READY) begin
          mode_d = (item_i.opcode == OP_SCAN) ? MODE_CH0 : MODE_CUR;
          cnt_d  = '0;
          sum_d  = '0;
          ok     = 1'b1;
          req    = 1'b1;
          chan   = (item_i.opcode == OP_SCAN) ? CH_W'(0) : CH_CUR;
        end
      end
      OP_SAMPLE: begin
        if (mode_q inside {MODE_CH0, MODE_CH1, MODE_CH2, MODE_CH3, MODE_CUR}) begin
          ok = 1'b1;
          if (cnt_inc != '0 && cnt_inc >= NCnt) begin
            cnt_d = '0;
            sum_d = '0;
            if (mode_q == MODE_CUR) begin
              cur_d  = mean;
              mode_d = MODE_READY;
              done   = 1'b1;
            end else begin
              avg_d[scan_ch] = mean;
              case (mode_q)
                MODE_CH0: mode_d = MODE_CH1;
                MODE_CH1: mode_d = MODE_CH2;
                MODE_CH2: mode_d = MODE_CH3;
                default:  mode_d = MODE_READY;
              endcase
              if (mode_q == MODE_CH3) begin
                done = 1'b1;
              end else begin
                req  = 1'b1;
                chan = scan_ch + CH_W'(1);
              end
            end
          end else begin
            cnt_d = cnt_inc;
            sum_d = sum_inc;
            req   = 1'b1;
            chan  = (mode_q == MODE_CUR) ? CH_CUR : scan_ch;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      cnt_q  <= '0;
      sum_q  <= '0;
      for (int i = 0; i < NUM_CH; i++) avg_q[i] <= '0;
      cur_q  <= '0;
    end else if (step_i) begin
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
      sum_q  <= sum_d;
      avg_q  <= avg_d;
      cur_q  <= cur_d;
    end
  end

  always_comb begin
    res_o.ok              = ok;
    res_o.request_valid   = req;
    res_o.request_channel = chan;
    res_o.done_res        = done;
    res_o.average_ch0     = avg_d[0];
    res_o.average_ch1     = avg_d[1];
    res_o.average_ch2     = avg_d[2];
    res_o.average_ch3     = avg_d[3];
    res_o.current_average = cur_d;
  end

endmodule

[rtl/adc_averaging_scan_sequencer.sv]
// Top level of the ADC averaging scan sequencer: request pipeline and checks.
//
// Each accepted request (open, close, start scan, start current reading, or
// an arrived sample) produces exactly one result two stages later: a request
// register, then the step logic and the constant divider, then a result
// register. One request per cycle is taken while the result side keeps up.
// Channel means are formed as (sum + N/2) / N with N = SAMPLES_PER_CHANNEL
// (1..15), using an exact reciprocal multiply. A scan walks channels 0..3, a
// current reading uses channel 3 once; done_res flags completion and every
// result reports all stored means.
module adc_averaging_scan_sequencer
  import aass_pkg::*;
#(
  parameter int unsigned SAMPLES_PER_CHANNEL = 10
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  // request stage
  logic      s1_valid_q;
  in_item_t  s1_data_q;
  // result stage
  logic      out_valid_q;
  out_item_t out_data_q;

  logic      advance;
  logic      in_fire;
  out_item_t res;

  // move the held request into the result register when the slot is free
  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;
  assign in_fire    = in_valid_i && in_ready_o;

  aass_seq #(
    .SAMPLES_PER_CHANNEL(SAMPLES_PER_CHANNEL)
  ) u_seq (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(advance),
    .item_i(s1_data_q),
    .res_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_data_q <= in_data_i;
    end
    if (advance) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // completion never comes with a new conversion request
  a_done_no_req : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.done_res |-> !out_data_o.request_valid)
    else $error("done_res with request_valid");

  // requests and completions only on accepted commands
  a_req_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.request_valid || out_data_o.done_res) |-> out_data_o.ok)
    else $error("request or done on refused command");

  // an empty pipeline always takes a request
  a_empty_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> in_ready_o)
    else $error("empty pipeline not ready");

  // a request moved out of the request stage shows up as a valid result next cycle
  a_flow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_o)
    else $error("advanced request lost");

endmodule

[tb/sv/sequencer_checker.sv]
`timescale 1ns / 100ps
// Checker for the ADC averaging scan sequencer: predicts each request's result and compares.
module sequencer_checker
  import aass_pkg::*;
#(
  parameter int unsigned SAMPLES_PER_CHANNEL = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  in_item_t    in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  out_item_t   out_data_i,
  output int unsigned error_count_o,
  output int unsigned outstanding_o
);

  mode_e               mode_q;
  logic [CNT_W-1:0]    count_q;
  logic [SUM_W-1:0]    sum_q;
  logic [SAMPLE_W-1:0] means_q [NUM_CH];
  logic [SAMPLE_W-1:0] current_q;
  out_item_t           predicted_reports [$];
  int unsigned         errors = 0;

  assign error_count_o = errors;

  function automatic logic [CH_W-1:0] scan_channel(mode_e m);
    case (m)
      MODE_CH1: return 2'd1;
      MODE_CH2: return 2'd2;
      MODE_CH3: return 2'd3;
      default:  return 2'd0;
    endcase
  endfunction

  task automatic predict_step(input in_item_t req, output out_item_t res);
    logic [SAMPLE_W-1:0] mean;
    logic [CH_W-1:0]     ch;
    res = '0;
    case (req.opcode)
      OP_OPEN: if (mode_q == MODE_IDLE) begin
        mode_q = MODE_READY;
        res.ok = 1'b1;
      end
      OP_CLOSE: if (mode_q != MODE_IDLE) begin
        // sum and count survive a close; the next start clears them
        mode_q = MODE_IDLE;
        res.ok = 1'b1;
      end
      OP_SCAN, OP_CUR: if (mode_q == MODE_READY) begin
        mode_q              = (req.opcode == OP_SCAN) ? MODE_CH0 : MODE_CUR;
        count_q             = '0;
        sum_q               = '0;
        res.ok              = 1'b1;
        res.request_valid   = 1'b1;
        res.request_channel = (req.opcode == OP_SCAN) ? 2'd0 : CH_CUR;
      end
      OP_SAMPLE: if (mode_q != MODE_IDLE && mode_q != MODE_READY) begin
        res.ok  = 1'b1;
        sum_q   = sum_q + SUM_W'(req.sample);
        count_q = count_q + 1'b1;
        ch      = (mode_q == MODE_CUR) ? CH_CUR : scan_channel(mode_q);
        if (count_q != '0 && count_q >= SAMPLES_PER_CHANNEL) begin
          mean    = SAMPLE_W'((int'(sum_q) + int'(count_q >> 1)) / int'(count_q));
          count_q = '0;
          sum_q   = '0;
          if (mode_q == MODE_CUR) begin
            current_q    = mean;
            mode_q       = MODE_READY;
            res.done_res = 1'b1;
          end else begin
            means_q[ch] = mean;
            if (mode_q == MODE_CH3) begin
              mode_q       = MODE_READY;
              res.done_res = 1'b1;
            end else begin
              mode_q              = mode_e'(mode_q << 1);
              res.request_valid   = 1'b1;
              res.request_channel = ch + 1'b1;
            end
          end
        end else begin
          res.request_valid   = 1'b1;
          res.request_channel = ch;
        end
      end
      default: ;
    endcase
    res.average_ch0     = means_q[0];
    res.average_ch1     = means_q[1];
    res.average_ch2     = means_q[2];
    res.average_ch3     = means_q[3];
    res.current_average = current_q;
  endtask

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    out_item_t predicted;
    out_item_t oldest;
    if (!rst_ni) begin
      mode_q    = MODE_IDLE;
      count_q   = '0;
      sum_q     = '0;
      current_q = '0;
      for (int i = 0; i < NUM_CH; i++) means_q[i] = '0;
      predicted_reports.delete();
      outstanding_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        predict_step(in_data_i, predicted);
        predicted_reports.push_back(predicted);
      end
      if (out_valid_i && out_ready_i) begin
        if (predicted_reports.size() == 0) begin
          errors++;
          $display("%0t: result with none expected, got %h", $time, out_data_i);
        end else begin
          oldest = predicted_reports.pop_front();
          compare_field("ok", oldest.ok, out_data_i.ok);
          compare_field("request_valid", oldest.request_valid, out_data_i.request_valid);
          compare_field("request_channel", oldest.request_channel,
                        out_data_i.request_channel);
          compare_field("done_res", oldest.done_res, out_data_i.done_res);
          compare_field("average_ch0", oldest.average_ch0, out_data_i.average_ch0);
          compare_field("average_ch1", oldest.average_ch1, out_data_i.average_ch1);
          compare_field("average_ch2", oldest.average_ch2, out_data_i.average_ch2);
          compare_field("average_ch3", oldest.average_ch3, out_data_i.average_ch3);
          compare_field("current_average", oldest.current_average,
                        out_data_i.current_average);
        end
      end
      outstanding_o <= predicted_reports.size();
    end
  end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
// Testbench top for the ADC averaging scan sequencer: stimulus, idling and verdict.
module testbench;
  import aass_pkg::*;

  localparam int unsigned SAMPLES_PER_CHANNEL = 10;
  localparam int unsigned NUM_PHASES          = 4;
  localparam int unsigned ITEMS_PER_PHASE     = 475;
  localparam int unsigned SCAN_SAMPLES        = NUM_CH * SAMPLES_PER_CHANNEL;

  // opcodes the block does not define; each must be refused
  localparam logic [2:0] OP_UNUSED_LO  = 3'd5;
  localparam logic [2:0] OP_UNUSED_MID = 3'd6;
  localparam logic [2:0] OP_UNUSED_HI  = 3'd7;

  // content of the samples within one reading
  typedef enum int unsigned {
    STYLE_FULL_SCALE,
    STYLE_ZERO,
    STYLE_LOW,
    STYLE_ANY
  } sample_style_e;

  // idling per phase: none, sender only, receiver only, both
  int unsigned sender_idle_pct    [NUM_PHASES] = '{0, 46, 0, 38};
  int unsigned receiver_stall_pct [NUM_PHASES] = '{0, 0, 46, 38};

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  in_item_t    in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  int unsigned error_count;
  int unsigned outstanding;

  int unsigned idle_pct      = 0;
  int unsigned stall_pct     = 0;
  int unsigned requests_sent = 0;

  always #2 clk = ~clk;

  adc_averaging_scan_sequencer #(
    .SAMPLES_PER_CHANNEL(SAMPLES_PER_CHANNEL)
  ) u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  sequencer_checker #(
    .SAMPLES_PER_CHANNEL(SAMPLES_PER_CHANNEL)
  ) u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .error_count_o(error_count),
    .outstanding_o(outstanding)
  );

  // Result side: stall at the phase's rate, redrawn every cycle.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Presents one request and holds it until taken. Afterwards the sender may
  // go idle at the phase's rate; valid is only lowered when a gap is chosen, so
  // back-to-back requests keep valid high with a single assignment per edge.
  task automatic send_request(input logic [2:0] op, input logic [SAMPLE_W-1:0] smp);
    in_valid <= 1'b1;
    in_data  <= '{opcode: op, sample: smp};
    do @(posedge clk); while (!in_ready);
    requests_sent++;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample(input sample_style_e style);
    case (style)
      STYLE_FULL_SCALE: return '1;
      STYLE_ZERO:       return '0;
      // small values make the rounding term matter
      STYLE_LOW:        return SAMPLE_W'($urandom_range(15));
      default:          return SAMPLE_W'($urandom);
    endcase
  endfunction

  initial begin : stimulus
    int unsigned   kind;
    int unsigned   cut;
    int unsigned   stray;
    sample_style_e style;
    bit            block_ready;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: refusals while idle, open, refusals while ready, the unused
    // opcodes, a full-scale current reading, then refusals during a scan and
    // a close in the middle of a reading.
    send_request(OP_SAMPLE, '1);
    send_request(OP_CLOSE, '0);
    send_request(OP_SCAN, '0);
    send_request(OP_CUR, '0);
    send_request(OP_OPEN, '0);
    send_request(OP_OPEN, '1);
    send_request(OP_SAMPLE, '1);
    send_request(OP_UNUSED_LO, '1);
    send_request(OP_UNUSED_MID, '0);
    send_request(OP_UNUSED_HI, '1);
    send_request(OP_CUR, '0);
    repeat (SAMPLES_PER_CHANNEL) send_request(OP_SAMPLE, '1);
    send_request(OP_SCAN, '0);
    send_request(OP_SCAN, '0);
    send_request(OP_CUR, '0);
    send_request(OP_OPEN, '0);
    send_request(OP_SAMPLE, '0);
    send_request(OP_CLOSE, '0);
    send_request(OP_CLOSE, '0);
    block_ready = 1'b0;

    for (int unsigned phase = 0; phase < NUM_PHASES; phase++) begin
      idle_pct  = sender_idle_pct[phase];
      stall_pct = receiver_stall_pct[phase];
      while (requests_sent < (phase + 1) * ITEMS_PER_PHASE) begin
        kind  = $urandom_range(99);
        style = sample_style_e'($urandom_range(3));
        if (kind < 90 && !block_ready) begin
          // close then open lands in ready from any mode
          send_request(OP_CLOSE, SAMPLE_W'($urandom));
          send_request(OP_OPEN, SAMPLE_W'($urandom));
        end
        if (kind < 50) begin
          // complete four-channel scan
          send_request(OP_SCAN, SAMPLE_W'($urandom));
          repeat (SCAN_SAMPLES) send_request(OP_SAMPLE, pick_sample(style));
          block_ready = 1'b1;
        end else if (kind < 78) begin
          // complete current reading
          send_request(OP_CUR, SAMPLE_W'($urandom));
          repeat (SAMPLES_PER_CHANNEL) send_request(OP_SAMPLE, pick_sample(style));
          block_ready = 1'b1;
        end else if (kind < 90) begin
          // reading cut short: a refused start or open, then a close with
          // a partial sum left behind for the next start to clear
          if ($urandom_range(1) != 0) begin
            send_request(OP_SCAN, SAMPLE_W'($urandom));
            cut = $urandom_range(SCAN_SAMPLES - 1);
          end else begin
            send_request(OP_CUR, SAMPLE_W'($urandom));
            cut = $urandom_range(SAMPLES_PER_CHANNEL - 1);
          end
          repeat (cut) send_request(OP_SAMPLE, pick_sample(style));
          stray = $urandom_range(2);
          send_request(stray == 0 ? OP_OPEN : (stray == 1 ? OP_SCAN : OP_CUR),
                       SAMPLE_W'($urandom));
          send_request(OP_CLOSE, SAMPLE_W'($urandom));
          block_ready = 1'b0;
        end else begin
          // noise: any opcode, any sample, from whatever mode we are in
          repeat ($urandom_range(1, 6))
            send_request(3'($urandom_range(7)), SAMPLE_W'($urandom));
          block_ready = 1'b0;
        end
      end
      // hold off until every predicted result has come back
      in_valid <= 1'b0;
      @(posedge clk);
      wait (outstanding == 0);
      @(posedge clk);
    end

    // run on a little longer to catch any stray result
    repeat (16) @(posedge clk);
    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
